[sv/address_range_remap_table_macros.svh]
// Assertion macros for the address range remap table.
`ifndef ADDRESS_RANGE_REMAP_TABLE_MACROS_SVH
`define ADDRESS_RANGE_REMAP_TABLE_MACROS_SVH
`ifndef SYNTHESIS
// Implication checked on every clock edge outside reset.
`define ARA_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("address range remap table: implication check failed");
// Condition that must hold in the cycle after a reset edge.
`define ARA_ASSERT_AFTER_RST(label, clk, rst, cons) \
  label: assert property (@(posedge clk) (rst) |=> (cons)) \
    else $error("address range remap table: post-reset check failed");
`else
`define ARA_ASSERT_IMP(label, clk, rst, ante, cons)
`define ARA_ASSERT_AFTER_RST(label, clk, rst, cons)
`endif
`endif

[sv/ara_pkg.sv]
// Shared constants, types and codes of the address range remap table.
package ara_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int ADDR_BITS     = 64;
  localparam int FIELD_W       = 64;
  localparam int LEN_W         = 64;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_EXISTS = 2'd3
  } req_op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_DISABLED  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DRAIN,
    BK_COMMIT
  } back_state_t;

  typedef struct packed {
    req_op_t               op;
    logic                  disabled;
    logic [ADDR_BITS-1:0]  addr;
    logic [ADDR_BITS-1:0]  actual;
    logic [LEN_W-1:0]      length;
  } req_item_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0]  base;
    logic [ADDR_BITS-1:0]  actual;
    logic [LEN_W-1:0]      length;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

[sv/ara_front.sv]
// Front end: holds the enable register, accepts requests and classifies them.
module ara_front
  import ara_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         req_type,
  input  logic [FIELD_W-1:0] req_addr,
  input  logic [FIELD_W-1:0] target_addr,
  input  logic [FIELD_W-1:0] region_size,
  input  queue_stat_t        q_stat,
  output logic               push,
  output req_item_t          push_item
);

  logic enabled;

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= 1'b0;
    end else if (cfg_wr_en) begin
      enabled <= cfg_wr_data;
    end
  end

  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;

  // Addresses are cut to the table's address width; a disabled table is
  // recorded with the request so the back end never looks at the register.
  always_comb begin
    push_item.op       = req_op_t'(req_type);
    push_item.disabled = !enabled;
    push_item.addr     = req_addr[ADDR_BITS-1:0];
    push_item.actual   = target_addr[ADDR_BITS-1:0];
    push_item.length   = region_size[LEN_W-1:0];
  end

endmodule

[sv/ara_queue.sv]
// Short request queue between the front end and the table scanner.
module ara_queue
  import ara_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  req_item_t   push_item,
  input  logic        pop,
  output req_item_t   head,
  output queue_stat_t q_stat
);

  req_item_t         slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  assign head         = slots[rd_ptr];
  assign q_stat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_stat.empty = (count == '0);

endmodule

[sv/ara_back.sv]
// Back end: scans the region table for one request and drives the result register.
module ara_back
  import ara_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  req_item_t          head,
  input  queue_stat_t        q_stat,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [FIELD_W-1:0] result_addr,
  output logic               hit
);

  back_state_t state;
  back_state_t state_next;

  req_item_t   cur;
  logic [IDX_W-1:0] scan_idx;
  logic [IDX_W-1:0] rd_idx;
  logic             rd_live;
  entry_t           rd_data;
  entry_t           mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] entry_valid;

  logic                 exact_found;
  logic [IDX_W-1:0]     exact_idx;
  logic [ADDR_BITS-1:0] exact_actual;
  logic                 range_found;
  logic [ADDR_BITS-1:0] range_actual;
  logic [ADDR_BITS-1:0] range_diff;
  logic                 free_found;
  logic [IDX_W-1:0]     free_idx;

  logic                 out_free;
  logic                 mem_we;
  logic                 valid_set;
  logic                 valid_clr;
  logic [IDX_W-1:0]     wr_idx;
  logic                 out_load;
  status_t              res_status;
  logic [ADDR_BITS-1:0] res_addr;
  logic                 res_hit;

  logic                 rd_v;
  logic                 exact_m;
  logic                 range_m;
  logic [ADDR_BITS-1:0] diff;

  assign out_free = !out_valid || !out_stall;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          state_next = head.disabled ? BK_COMMIT : BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (scan_idx == IDX_W'(TABLE_ENTRIES - 1)) begin
          state_next = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        state_next = BK_COMMIT;
      end
      BK_COMMIT: begin
        if (out_free) begin
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // Per-entry match tests on the registered read data.
  always_comb begin
    rd_v    = entry_valid[rd_idx];
    diff    = cur.addr - rd_data.base;
    exact_m = rd_v && (rd_data.base == cur.addr);
    range_m = rd_v && (cur.addr >= rd_data.base) && (LEN_W'(diff) < rd_data.length);
  end

  // Outputs of the sequencer: queue pop, table update and result.
  always_comb begin
    pop        = 1'b0;
    mem_we     = 1'b0;
    valid_set  = 1'b0;
    valid_clr  = 1'b0;
    out_load   = 1'b0;
    wr_idx     = exact_found ? exact_idx : free_idx;
    res_status = ST_OK;
    res_addr   = '0;
    res_hit    = 1'b0;
    case (state)
      BK_IDLE: begin
        pop = !q_stat.empty;
      end
      BK_COMMIT: begin
        out_load = out_free;
        if (cur.disabled) begin
          res_status = ST_DISABLED;
          if (cur.op == OP_LOOKUP) begin
            res_addr = cur.addr;
          end
        end else begin
          case (cur.op)
            OP_ADD: begin
              if (exact_found || free_found) begin
                mem_we    = out_free;
                valid_set = out_free;
              end else begin
                res_status = ST_FULL;
              end
            end
            OP_REMOVE: begin
              if (exact_found) begin
                valid_clr = out_free;
              end else begin
                res_status = ST_NOT_FOUND;
              end
            end
            OP_LOOKUP: begin
              if (exact_found) begin
                res_addr = exact_actual;
                res_hit  = 1'b1;
              end else if (range_found) begin
                res_addr = range_actual + range_diff;
                res_hit  = 1'b1;
              end else begin
                res_addr   = cur.addr;
                res_status = ST_NOT_FOUND;
              end
            end
            OP_EXISTS: begin
              if (exact_found) begin
                res_hit = 1'b1;
              end else begin
                res_status = ST_NOT_FOUND;
              end
            end
            default: begin
              res_status = ST_OK;
            end
          endcase
        end
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= BK_IDLE;
      rd_live     <= 1'b0;
      out_valid   <= 1'b0;
      entry_valid <= '0;
    end else begin
      state   <= state_next;
      rd_live <= (state == BK_SCAN);
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (valid_set) begin
        entry_valid[wr_idx] <= 1'b1;
      end
      if (valid_clr) begin
        entry_valid[exact_idx] <= 1'b0;
      end
    end
  end

  // Region storage: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_idx] <= '{base: cur.addr, actual: cur.actual, length: cur.length};
    end
    rd_data <= mem[scan_idx];
  end

  // Scan bookkeeping; the first hit of each kind is kept.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur         <= head;
      scan_idx    <= '0;
      exact_found <= 1'b0;
      range_found <= 1'b0;
      free_found  <= 1'b0;
    end else if (state == BK_SCAN) begin
      scan_idx <= scan_idx + 1'b1;
    end
    rd_idx <= scan_idx;
    if (rd_live && !pop) begin
      if (exact_m && !exact_found) begin
        exact_found  <= 1'b1;
        exact_idx    <= rd_idx;
        exact_actual <= rd_data.actual;
      end
      if (range_m && !range_found) begin
        range_found  <= 1'b1;
        range_actual <= rd_data.actual;
        range_diff   <= diff;
      end
      if (!rd_v && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= rd_idx;
      end
    end
    if (out_load) begin
      status      <= res_status;
      result_addr <= FIELD_W'(res_addr);
      hit         <= res_hit;
    end
  end

endmodule

[sv/address_range_remap_table.sv]
// With the table enabled a request goes from the queue through a scan of all
// entries and the drain state, then the commit state loads the result; with
// the table disabled it goes from the queue to the commit state. The back end
// serves one request at a time, bound by the single read port of the region
// memory, which the scan walks one entry a cycle. Reset (rst, synchronous) clears
// the enable register, all entry valid bits, the request queue and the result flag.
`include "address_range_remap_table_macros.svh"

module address_range_remap_table
  import ara_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         req_type,
  input  logic [FIELD_W-1:0] req_addr,
  input  logic [FIELD_W-1:0] target_addr,
  input  logic [FIELD_W-1:0] region_size,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [FIELD_W-1:0] result_addr,
  output logic               hit
);

  // The front end takes a transfer whenever the queue has room, so it keeps
  // accepting requests while the back end is still scanning or while a
  // finished result waits in the output register.
  queue_stat_t q_stat;
  logic        push;
  req_item_t   push_item;
  logic        pop;
  req_item_t   head;

  ara_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .req_addr      (req_addr),
    .target_addr   (target_addr),
    .region_size   (region_size),
    .q_stat        (q_stat),
    .push          (push),
    .push_item     (push_item)
  );

  // The queue decouples the two halves; each side stalls on its own.
  ara_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  // For a request with the table enabled the back end walks every entry once,
  // noting the first exact base match, the first containing region and the first
  // free entry, then commits the table update and the result in its commit state.
  ara_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_stat      (q_stat),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .result_addr (result_addr),
    .hit         (hit)
  );

  // A hit is only ever reported together with an ok status.
  `ARA_ASSERT_IMP(a_hit_is_ok, clk, rst, out_valid && hit, status == ST_OK)
  // A disabled table never reports a hit.
  `ARA_ASSERT_IMP(a_disabled_no_hit, clk, rst, out_valid && (status == ST_DISABLED), !hit)
  // A full table answers an add with no hit and a zero address.
  `ARA_ASSERT_IMP(a_full_clean, clk, rst, out_valid && (status == ST_FULL), !hit && (result_addr == '0))
  // No result is presented right after reset.
  `ARA_ASSERT_AFTER_RST(a_reset_empty, clk, rst, !out_valid)

endmodule
